// ===== rtl/core/vps_pkg.sv =====
// Package for the vibration pulse sequencer: operation codes, register indexes,
// fixed widths, reset values, battery thresholds and the packed result type.
// No dependencies.
package vps_pkg;

	// Fixed widths of the item fields
	localparam int unsigned OP_W    = 2;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned CFG_IDX_W = 3;

	// Operation codes carried on s_tuser
	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd1;
	localparam logic [OP_W-1:0] OP_BATTERY = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_MS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSES  = 3'd4;

	// Register reset values
	localparam logic [MS_W-1:0]    SHORT_MS_RESET   = 16'd60;
	localparam logic [MS_W-1:0]    GAP_MS_RESET     = 16'd120;
	localparam logic [COUNT_W-1:0] MAX_PULSES_RESET = 8'd20;

	// Battery alert thresholds
	localparam logic [PCT_W-1:0] LOW_LIMIT   = 7'd5;
	localparam logic [PCT_W-1:0] REARM_VALUE = 7'd101;
	localparam logic [PCT_W-1:0] FULL_PCT    = 7'd100;

	// One result item, highest field first
	typedef struct packed {
		logic [COUNT_W-1:0] pending_pulses;
		logic               accepted;
		logic               ready_res;
		logic               motor_level;
	} res_t;

endpackage

// ===== rtl/core/vibration_pulse_sequencer.sv =====
// Vibration pulse sequencer top level: event decode, pulse queue, countdown
// and result register. Depends on vps_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  s_*      | s_tvalid/s_tready  | s_tuser op, s_tdata count/first/battery
//  m_*      | m_tvalid/m_tready  | m_tdata motor_level/ready_res/accepted/pending
//  cfg_*    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per clock while no result waits on a low m_tready: each accepted item
// updates the state and loads the result register in the same cycle, so the result is valid in the cycle after.
// The result register is the only stall point; s_tready drops only while a
// result waits and m_tready is low. cfg_ready is always high.
// arst_n clears state and loads register reset values; no clearing pass.
module vibration_pulse_sequencer #(
	parameter int unsigned DURATION_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,   // pulse_count[7:0], first_duration[23:8],
	                                                // battery_percent[30:24], zero[31]
	input  logic [vps_pkg::OP_W-1:0]     s_tuser,   // op[1:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [15:0]                  m_tdata,   // motor_level[0], ready_res[1],
	                                                // accepted[2], pending_pulses[10:3],
	                                                // zero[15:11]
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [vps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                  cfg_data
);
	import vps_pkg::*;

	localparam int unsigned DW = DURATION_WIDTH;

	// Stage codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ON   = 2'd1;
	localparam logic [1:0] ST_GAP  = 2'd2;

	// Fit a 16-bit duration into DW bits
	function automatic logic [DW-1:0] fit_dur(input logic [MS_W-1:0] v);
		logic [DW+MS_W-1:0] w;
		w = {{DW{1'b0}}, v};
		return w[DW-1:0];
	endfunction

	// Configuration registers
	logic               enable_q;
	logic               active_high_q;
	logic [MS_W-1:0]    short_ms_q;
	logic [MS_W-1:0]    gap_ms_q;
	logic [COUNT_W-1:0] max_pulses_q;

	// Sequencer state
	logic [1:0]         stage_q;
	logic [COUNT_W-1:0] pending_q;
	logic [DW-1:0]      next_len_q;
	logic [DW-1:0]      remain_q;
	logic [PCT_W-1:0]   last_alert_q;

	// Result register
	logic               out_valid_q;
	res_t               res_q;

	// Item fields
	logic [OP_W-1:0]    in_op;
	logic [COUNT_W-1:0] in_count;
	logic [MS_W-1:0]    in_first;
	logic [PCT_W-1:0]   in_pct;

	logic               in_fire;
	logic               cfg_fire;
	logic               cfg_clear;

	// Next-state values
	logic [1:0]         stage_n;
	logic [COUNT_W-1:0] pending_n;
	logic [DW-1:0]      next_len_n;
	logic [DW-1:0]      remain_n;
	logic [PCT_W-1:0]   last_alert_n;
	logic               acc_n;
	logic               on_n;
	res_t               res_n;

	// Enqueue helper signals
	logic               enq_go;
	logic [COUNT_W-1:0] enq_cnt;
	logic [DW-1:0]      enq_first;
	logic [COUNT_W-1:0] limit;
	logic [COUNT_W:0]   total;
	logic [COUNT_W-1:0] total_sat;
	logic               stage_busy;
	logic [DW-1:0]      remain_dec;
	logic [PCT_W-1:0]   pct_drop;

	assign in_op    = s_tuser;
	assign in_count = s_tdata[7:0];
	assign in_first = s_tdata[23:8];
	assign in_pct   = s_tdata[30:24];

	assign s_tready  = !out_valid_q || m_tready;
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cfg_clear = cfg_fire && (cfg_index == REG_ENABLE) && !cfg_data[0];

	// Shared arithmetic for enqueue and countdown
	assign limit      = (max_pulses_q == '0) ? COUNT_W'(1) : max_pulses_q;
	assign total      = {1'b0, pending_q} + {1'b0, enq_cnt};
	assign total_sat  = (total > {1'b0, limit}) ? limit : total[COUNT_W-1:0];
	assign stage_busy = (stage_q == ST_ON) || (stage_q == ST_GAP);
	assign remain_dec = (remain_q != '0) ? remain_q - DW'(1) : '0;
	assign pct_drop   = last_alert_q - in_pct;

	// Decode the item and pick the enqueue request
	always_comb begin
		enq_go    = 1'b0;
		enq_cnt   = '0;
		enq_first = fit_dur(short_ms_q);
		last_alert_n = last_alert_q;
		case (in_op)
			OP_ENQUEUE: begin
				enq_go  = enable_q && (in_count != '0);
				enq_cnt = in_count;
				if (in_first != '0) begin
					enq_first = fit_dur(in_first);
				end
			end
			OP_BATTERY: begin
				if (enable_q && (in_pct <= FULL_PCT)) begin
					if (in_pct > LOW_LIMIT) begin
						last_alert_n = REARM_VALUE;
					end else if (last_alert_q > LOW_LIMIT) begin
						enq_go       = 1'b1;
						enq_cnt      = COUNT_W'(1);
						last_alert_n = in_pct;
					end else if (in_pct < last_alert_q) begin
						enq_go       = 1'b1;
						enq_cnt      = {{(COUNT_W-PCT_W){1'b0}}, pct_drop};
						last_alert_n = in_pct;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Advance the stage machine, queue and countdown for one item
	always_comb begin
		stage_n    = stage_busy ? stage_q : ST_IDLE;
		pending_n  = pending_q;
		next_len_n = next_len_q;
		remain_n   = remain_q;
		acc_n      = 1'b0;
		case (in_op)
			OP_TICK: begin
				if (enable_q) begin
					if (stage_busy) begin
						remain_n = remain_dec;
						if (remain_dec == '0) begin
							if (stage_q == ST_ON) begin
								stage_n  = ST_GAP;
								remain_n = fit_dur(gap_ms_q);
							end else begin
								stage_n = ST_IDLE;
								if (pending_q != '0) begin
									pending_n = pending_q - COUNT_W'(1);
								end
							end
						end
					end else if (pending_q != '0) begin
						stage_n    = ST_ON;
						remain_n   = next_len_q;
						next_len_n = fit_dur(short_ms_q);
					end
				end
			end
			OP_ENQUEUE, OP_BATTERY: begin
				if (enq_go) begin
					acc_n     = 1'b1;
					pending_n = total_sat;
					if ((pending_q == '0) && !stage_busy) begin
						next_len_n = enq_first;
					end
				end
			end
			default: begin
				pending_n = '0;
				stage_n   = ST_IDLE;
			end
		endcase
	end

	// Form the result item
	always_comb begin
		on_n                 = (stage_n == ST_ON);
		res_n.motor_level    = active_high_q ? on_n : !on_n;
		res_n.ready_res      = (stage_n == ST_IDLE) && (pending_n == '0);
		res_n.accepted       = acc_n;
		res_n.pending_pulses = pending_n;
	end

	// Hold configuration and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			active_high_q <= 1'b1;
			short_ms_q    <= SHORT_MS_RESET;
			gap_ms_q      <= GAP_MS_RESET;
			max_pulses_q  <= MAX_PULSES_RESET;
			stage_q       <= ST_IDLE;
			pending_q     <= '0;
			next_len_q    <= fit_dur(SHORT_MS_RESET);
			remain_q      <= '0;
			last_alert_q  <= REARM_VALUE;
		end else begin
			// Disabling drops the queue ahead of any item in the same cycle
			if (cfg_clear) begin
				pending_q <= '0;
				stage_q   <= ST_IDLE;
			end else if (in_fire) begin
				stage_q   <= stage_n;
				pending_q <= pending_n;
			end
			if (in_fire) begin
				next_len_q   <= next_len_n;
				remain_q     <= remain_n;
				last_alert_q <= last_alert_n;
			end
			if (cfg_fire) begin
				case (cfg_index)
					REG_ENABLE:      enable_q      <= cfg_data[0];
					REG_ACTIVE_HIGH: active_high_q <= cfg_data[0];
					REG_SHORT_MS:    short_ms_q    <= cfg_data;
					REG_GAP_MS:      gap_ms_q      <= cfg_data;
					REG_MAX_PULSES:  max_pulses_q  <= cfg_data[COUNT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, res_q};

`ifndef SYNTHESIS
	// A running pulse always has a pending count behind it
	a_busy_has_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_q == ST_ON || stage_q == ST_GAP) |-> (pending_q != '0))
		else $error("sequencer busy with empty queue");

	// A disabled block stays idle
	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!enable_q |-> (stage_q == ST_IDLE))
		else $error("disabled block left idle stage");

	// Input stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (out_valid_q && !m_tready))
		else $error("input stalled without a waiting result");

	// An accepted item always leaves a result behind
	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted item produced no result");
`endif

endmodule
